@@ hdl/mrp_pkg.sv @@
package mrp_pkg;

  // coordinate width, wide enough for padded splits and their sums
  localparam int CW = 18;

  // item kinds
  localparam logic KIND_RESTART = 1'b0;
  localparam logic KIND_PLACE   = 1'b1;

  // result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOFIT    = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_FAILED   = 3'd4;

  typedef struct packed {
    logic        kind;
    logic [12:0] rect_width;
    logic [12:0] rect_height;
  } item_t;

  typedef struct packed {
    logic [11:0] placed_x;
    logic [11:0] placed_y;
    logic [2:0]  status;
  } result_t;

  // one stored free rectangle, with a live flag used while pruning
  typedef struct packed {
    logic                 alive;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] w;
    logic signed [CW-1:0] h;
  } frect_t;

  function automatic logic signed [CW-1:0] ext13(input logic [12:0] v);
    return signed'({{(CW-13){1'b0}}, v});
  endfunction

  function automatic logic signed [CW-1:0] ext8(input logic [7:0] v);
    return signed'({{(CW-8){1'b0}}, v});
  endfunction

  // a lies within b
  function automatic logic enclosed(input frect_t a, input frect_t b);
    return (a.y >= b.y) && (a.x >= b.x) &&
           (a.x + a.w <= b.x + b.w) && (a.y + a.h <= b.y + b.h);
  endfunction

endpackage

@@ hdl/mrp_ram.sv @@
module mrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/mrp_engine.sv @@
module mrp_engine #(
  parameter int MAX_FREE = 64,
  parameter int MAX_DIM  = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  mrp_pkg::item_t              item,
  output logic                        done,
  output mrp_pkg::result_t            result,
  input  logic [7:0]                  padding,
  output logic                        a_we,
  output logic [$clog2(MAX_FREE)-1:0] a_waddr,
  output mrp_pkg::frect_t             a_wdata,
  output logic [$clog2(MAX_FREE)-1:0] a_raddr,
  input  mrp_pkg::frect_t             a_rdata,
  output logic                        b_we,
  output logic [$clog2(MAX_FREE)-1:0] b_waddr,
  output mrp_pkg::frect_t             b_wdata,
  output logic [$clog2(MAX_FREE)-1:0] b_raddr,
  input  mrp_pkg::frect_t             b_rdata
);
  import mrp_pkg::*;

  localparam int AW   = $clog2(MAX_FREE);
  localparam int CNTW = $clog2(MAX_FREE + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN_RD = 4'd1;
  localparam logic [3:0] S_SCAN_EV = 4'd2;
  localparam logic [3:0] S_SPL_RD  = 4'd3;
  localparam logic [3:0] S_SPL_EV  = 4'd4;
  localparam logic [3:0] S_SPL_GEN = 4'd5;
  localparam logic [3:0] S_CPY_RD  = 4'd6;
  localparam logic [3:0] S_CPY_EV  = 4'd7;
  localparam logic [3:0] S_PII_RD  = 4'd8;
  localparam logic [3:0] S_PII_EV  = 4'd9;
  localparam logic [3:0] S_PJJ_RD  = 4'd10;
  localparam logic [3:0] S_PJJ_EV  = 4'd11;
  localparam logic [3:0] S_CMP_RD  = 4'd12;
  localparam logic [3:0] S_CMP_EV  = 4'd13;
  localparam logic [3:0] S_DONE    = 4'd14;

  logic [3:0]           state;
  logic [CNTW-1:0]      count;
  logic                 failed;
  logic [CNTW-1:0]      i;
  logic [CNTW-1:0]      k;
  logic [CNTW-1:0]      nsplit;
  logic [CNTW-1:0]      orig;
  logic [CNTW-1:0]      ii;
  logic [CNTW-1:0]      jj;
  logic signed [CW-1:0] best;
  logic                 found;
  logic signed [CW-1:0] bx;
  logic signed [CW-1:0] by;
  logic signed [CW-1:0] iw;
  logic signed [CW-1:0] ih;
  logic                 overflowed;
  logic [1:0]           sidx;
  frect_t               fr;
  frect_t               ri;
  logic                 done_next;

  // scan arithmetic
  logic signed [CW-1:0] lw, lh, lmin;
  logic                 better;

  // overlap of the placed item with the entry just read
  logic signed [CW-1:0] it_r, it_b;
  logic                 ovl;

  // split generation
  logic signed [CW-1:0] pad, fr_r, fr_b;
  logic                 split_ok;
  frect_t               split;
  logic [CNTW:0]        cur_count;
  logic                 room;

  logic                 jj_in_ii, ii_in_jj;

  assign busy = (state != S_IDLE);

  always_comb begin
    lw     = a_rdata.w - iw;
    lh     = a_rdata.h - ih;
    lmin   = (lw < lh) ? lw : lh;
    better = (lmin >= 0) && (lmin < best);
  end

  always_comb begin
    it_r = bx + iw;
    it_b = by + ih;
    ovl  = !((bx >= a_rdata.x + a_rdata.w) || (it_r <= a_rdata.x) ||
             (by >= a_rdata.y + a_rdata.h) || (it_b <= a_rdata.y));
  end

  // padded split in the order top, bottom, left, right
  always_comb begin
    pad      = ext8(padding);
    fr_r     = fr.x + fr.w;
    fr_b     = fr.y + fr.h;
    split    = fr;
    split.alive = 1'b1;
    split_ok = 1'b0;
    unique case (sidx)
      2'd0: begin
        split_ok = (by > fr.y);
        split.h  = by - fr.y - pad;
      end
      2'd1: begin
        split_ok = (fr_b > it_b);
        split.y  = it_b + pad;
        split.h  = fr_b - it_b - pad;
      end
      2'd2: begin
        split_ok = (bx > fr.x);
        split.w  = bx - fr.x - pad;
      end
      2'd3: begin
        split_ok = (fr_r > it_r);
        split.x  = it_r + pad;
        split.w  = fr_r - it_r - pad;
      end
      default: split_ok = 1'b0;
    endcase
    cur_count = {1'b0, k} + {1'b0, orig} - {1'b0, i} - (CNTW+1)'(1) + {1'b0, nsplit};
    room      = (cur_count < (CNTW+1)'(MAX_FREE));
  end

  always_comb begin
    ii_in_jj = enclosed(ri, a_rdata);
    jj_in_ii = enclosed(a_rdata, ri);
  end

  // memory access per state
  always_comb begin
    a_we    = 1'b0;
    a_waddr = k[AW-1:0];
    a_wdata = a_rdata;
    a_wdata.alive = 1'b1;
    unique case (state)
      S_PII_RD: a_raddr = ii[AW-1:0];
      S_PJJ_RD: a_raddr = jj[AW-1:0];
      default:  a_raddr = i[AW-1:0];
    endcase
    b_we    = (state == S_SPL_GEN) && split_ok && room;
    b_waddr = nsplit[AW-1:0];
    b_wdata = split;
    b_raddr = i[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (start && item.kind == KIND_RESTART) begin
          a_we    = 1'b1;
          a_waddr = '0;
          a_wdata = '{alive: 1'b1, x: '0, y: '0,
                      w: ext13(item.rect_width), h: ext13(item.rect_height)};
        end
      end
      S_SPL_EV: a_we = !ovl;
      S_CPY_EV: begin
        a_we    = 1'b1;
        a_wdata = b_rdata;
      end
      S_PJJ_EV: begin
        if (a_rdata.alive) begin
          if (ii_in_jj) begin
            a_we    = 1'b1;
            a_waddr = ii[AW-1:0];
            a_wdata = ri;
            a_wdata.alive = 1'b0;
          end else if (jj_in_ii) begin
            a_we    = 1'b1;
            a_waddr = jj[AW-1:0];
            a_wdata.alive = 1'b0;
          end
        end
      end
      S_CMP_EV: a_we = a_rdata.alive;
      default: a_we = 1'b0;
    endcase
  end

  // result strobe: immediate answers, no fit after the scan, end of a placement
  always_comb begin
    done_next = (state == S_DONE) ||
                ((state == S_SCAN_RD) && (i == count) && !found) ||
                ((state == S_IDLE) && start &&
                 !((item.kind == KIND_PLACE) && !failed && (count != '0)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_next;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      failed <= 1'b1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (item.kind == KIND_RESTART) begin
              result <= '{placed_x: '0, placed_y: '0, status: ST_OK};
              count  <= CNTW'(1);
              failed <= 1'b0;
            end else if (failed) begin
              result <= '{placed_x: '0, placed_y: '0, status: ST_FAILED};
            end else if (count == '0) begin
              result <= '{placed_x: '0, placed_y: '0, status: ST_EMPTY};
              failed <= 1'b1;
            end else begin
              iw    <= ext13(item.rect_width);
              ih    <= ext13(item.rect_height);
              best  <= CW'(MAX_DIM);
              found <= 1'b0;
              i     <= '0;
              state <= S_SCAN_RD;
            end
          end
        end
        S_SCAN_RD: begin
          if (i == count) begin
            if (!found) begin
              result <= '{placed_x: '0, placed_y: '0, status: ST_NOFIT};
              failed <= 1'b1;
              state  <= S_IDLE;
            end else begin
              i          <= '0;
              k          <= '0;
              nsplit     <= '0;
              orig       <= count;
              overflowed <= 1'b0;
              state      <= S_SPL_RD;
            end
          end else begin
            state <= S_SCAN_EV;
          end
        end
        S_SCAN_EV: begin
          if (better) begin
            best  <= lmin;
            found <= 1'b1;
            bx    <= a_rdata.x;
            by    <= a_rdata.y;
          end
          i     <= i + CNTW'(1);
          state <= S_SCAN_RD;
        end
        S_SPL_RD: begin
          if (i == orig) begin
            i     <= '0;
            state <= S_CPY_RD;
          end else begin
            state <= S_SPL_EV;
          end
        end
        S_SPL_EV: begin
          if (ovl) begin
            fr    <= a_rdata;
            sidx  <= '0;
            state <= S_SPL_GEN;
          end else begin
            k     <= k + CNTW'(1);
            i     <= i + CNTW'(1);
            state <= S_SPL_RD;
          end
        end
        S_SPL_GEN: begin
          if (split_ok) begin
            if (room) begin
              nsplit <= nsplit + CNTW'(1);
            end else begin
              overflowed <= 1'b1;
            end
          end
          sidx <= sidx + 2'd1;
          if (sidx == 2'd3) begin
            i     <= i + CNTW'(1);
            state <= S_SPL_RD;
          end
        end
        S_CPY_RD: begin
          if (i == nsplit) begin
            count <= k;
            ii    <= '0;
            state <= S_PII_RD;
          end else begin
            state <= S_CPY_EV;
          end
        end
        S_CPY_EV: begin
          k     <= k + CNTW'(1);
          i     <= i + CNTW'(1);
          state <= S_CPY_RD;
        end
        S_PII_RD: begin
          if (ii == count) begin
            i     <= '0;
            k     <= '0;
            state <= S_CMP_RD;
          end else begin
            state <= S_PII_EV;
          end
        end
        S_PII_EV: begin
          if (a_rdata.alive) begin
            ri    <= a_rdata;
            jj    <= ii + CNTW'(1);
            state <= S_PJJ_RD;
          end else begin
            ii    <= ii + CNTW'(1);
            state <= S_PII_RD;
          end
        end
        S_PJJ_RD: begin
          if (jj == count) begin
            ii    <= ii + CNTW'(1);
            state <= S_PII_RD;
          end else begin
            state <= S_PJJ_EV;
          end
        end
        S_PJJ_EV: begin
          if (a_rdata.alive && ii_in_jj) begin
            ii    <= ii + CNTW'(1);
            state <= S_PII_RD;
          end else begin
            jj    <= jj + CNTW'(1);
            state <= S_PJJ_RD;
          end
        end
        S_CMP_RD: begin
          if (i == count) begin
            count <= k;
            state <= S_DONE;
          end else begin
            state <= S_CMP_EV;
          end
        end
        S_CMP_EV: begin
          if (a_rdata.alive) begin
            k <= k + CNTW'(1);
          end
          i     <= i + CNTW'(1);
          state <= S_CMP_RD;
        end
        S_DONE: begin
          result <= '{placed_x: bx[11:0], placed_y: by[11:0],
                      status: overflowed ? ST_OVERFLOW : ST_OK};
          if (overflowed) begin
            failed <= 1'b1;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/maxrects_rect_placer_top.sv @@
// Free-rectangle atlas placer, best short side fit.
// Command channel: an item transfers on a rising edge with start high and
// busy low. kind restart resets the free list to one rectangle of the given
// atlas size; kind place looks for room for a rectangle of the given size.
// Result channel: done is high for exactly one cycle with result valid;
// the receiver cannot stall it and must take it in that cycle.
// Restart, and a place that fails at once (earlier failure, empty list),
// answer in the cycle after the transfer without raising busy.
// A place runs through the free list held in a dual-port RAM with a
// registered read port, each entry visit being a read state and then an
// evaluate state: a best-fit scan of the entries, a split pass (up to four
// splits per overlapped entry) with a copy of the new splits from a scratch
// RAM, a pairwise enclosure prune of about n*n/2 visits for n entries, and a
// compaction pass.
// Config channel: cfg_data (padding) is written when cfg_valid and cfg_ready
// are high; cfg_ready is always high, writes belong to idle periods.
// Reset (rst, synchronous) clears the list count and marks the placer as
// failed until the first restart; padding resets to zero.
module maxrects_rect_placer_top #(
  parameter int MAX_FREE = 64,
  parameter int MAX_DIM  = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  mrp_pkg::item_t    item,
  output logic              done,
  output mrp_pkg::result_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);
  import mrp_pkg::*;

  localparam int AW = $clog2(MAX_FREE);

  logic [7:0]    padding;
  logic          a_we, b_we;
  logic [AW-1:0] a_waddr, a_raddr, b_waddr, b_raddr;
  frect_t        a_wdata, a_rdata, b_wdata, b_rdata;

  // padding register write
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      padding <= '0;
    end else if (cfg_valid && cfg_ready) begin
      padding <= cfg_data;
    end
  end

  // free list
  mrp_ram #(.WIDTH($bits(frect_t)), .DEPTH(MAX_FREE)) u_list (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_rdata)
  );

  // scratch for new splits
  mrp_ram #(.WIDTH($bits(frect_t)), .DEPTH(MAX_FREE)) u_splits (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(b_raddr), .rdata(b_rdata)
  );

  mrp_engine #(.MAX_FREE(MAX_FREE), .MAX_DIM(MAX_DIM)) u_engine (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .padding(padding),
    .a_we(a_we), .a_waddr(a_waddr), .a_wdata(a_wdata),
    .a_raddr(a_raddr), .a_rdata(a_rdata),
    .b_we(b_we), .b_waddr(b_waddr), .b_wdata(b_wdata),
    .b_raddr(b_raddr), .b_rdata(b_rdata)
  );

endmodule
